>>> sv/hamming_encode_and_check_assert.svh
// Assertion macros shared by the Hamming encode and check block.
`ifndef HAMMING_ENCODE_AND_CHECK_ASSERT_SVH
`define HAMMING_ENCODE_AND_CHECK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked assertion that is switched off while reset is active.
`define HEC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hamming_encode_and_check assertion failed");

// Clocked assertion that also holds during reset.
`define HEC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("hamming_encode_and_check assertion failed");

`else

`define HEC_ASSERT(lbl, clk, rst_n, prop)
`define HEC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> sv/hec_pkg.sv
// Types, constants and constant functions of the Hamming encode and check block.
`timescale 1ns / 1ps

package hec_pkg;

    localparam int HEC_WORD_W        = 63;
    localparam int HEC_COUNT_W       = 6;
    localparam int HEC_GROUPS        = 6;
    localparam int HEC_DATA_W        = HEC_WORD_W - HEC_GROUPS;
    localparam int HEC_MAX_CODE_BITS = 63;
    localparam int HEC_QUEUE_DEPTH   = 2;

    typedef enum logic
    {
        CMD_ENCODE = 1'b0,
        CMD_CHECK  = 1'b1
    } hec_cmd_t;

    typedef struct packed
    {
        logic                   command;
        logic [HEC_COUNT_W-1:0] bit_count;
        logic [HEC_WORD_W-1:0]  word_bits;
    } hec_req_t;

    typedef struct packed
    {
        logic [HEC_WORD_W-1:0]  code_word;
        logic [HEC_COUNT_W-1:0] code_bits;
        logic                   parity_ok;
        logic                   length_error;
    } hec_rsp_t;

    // Classified job handed from the front end to the back end.
    typedef struct packed
    {
        logic                   is_check;
        logic                   length_error;
        logic [HEC_COUNT_W-1:0] code_bits;
        logic [HEC_WORD_W-1:0]  data;
    } hec_job_t;

    // Zero-based code index of data bit d: the d-th position that is not a power of two.
    function automatic logic [HEC_COUNT_W-1:0] hec_data_pos(input int d);
        int                     cnt;
        logic [HEC_COUNT_W-1:0] pos;
        cnt = 0;
        pos = '0;
        for (int p = 1; p <= HEC_WORD_W; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                if (cnt == d)
                begin
                    pos = HEC_COUNT_W'(p - 1);
                end
                cnt++;
            end
        end
        return pos;
    endfunction

    // Positions covered by parity group g, bit k-1 standing for code position k.
    function automatic logic [HEC_WORD_W-1:0] hec_group_mask(input int g);
        logic [HEC_WORD_W-1:0] mask;
        mask = '0;
        for (int k = 1; k <= HEC_WORD_W; k++)
        begin
            if ((k & (1 << g)) != 0)
            begin
                mask[HEC_COUNT_W'(k - 1)] = 1'b1;
            end
        end
        return mask;
    endfunction

    // Smallest r with 2^r >= m + r + 1.
    function automatic logic [2:0] hec_parity_count(input logic [HEC_COUNT_W-1:0] m);
        logic [2:0] r;
        r = 3'd7;
        for (int i = 7; i >= 0; i--)
        begin
            if ((9'd1 << i) >= (9'(m) + 9'(i) + 9'd1))
            begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> sv/hamming_encode_and_check.sv
// Top level of the Hamming encode and check block.
`timescale 1ns / 1ps

// Even-parity Hamming encoder and checker for variable-length words. A command
// word either encodes bit_count data bits into a code of m+r bits, with the
// parity bits at the power-of-two positions, or checks that every parity
// group of a bit_count-bit received code is even. Results come back one per
// command, in order. The block takes one command word per clock and returns
// one result word per clock in steady state while the result port does not
// stall. An accepted word's job is first written into the queue, and its
// result is then registered in the back end's result register before it is
// valid at the result port. The rate is set by the back end, whose scatter
// and parity trees are combinational, and by its result register. The front
// end sizes the code and masks unused bits in the accept cycle, then writes a
// two-entry queue; the queue lets the command side keep sending while a
// finished result waits on a stalled result port, and cmd_stall rises only
// when the queue is full. Encodes whose code would exceed MAX_CODE_BITS
// report length_error with an empty code; checks longer than MAX_CODE_BITS
// are cut to that length. There is no syndrome output and no correction.

module hamming_encode_and_check #(
    parameter int MAX_CODE_BITS = hec_pkg::HEC_MAX_CODE_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  hec_pkg::hec_req_t cmd_word,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output hec_pkg::hec_rsp_t rsp_word
);
    import hec_pkg::*;

    hec_job_t front_job;
    hec_job_t head_job;
    logic     queue_full;
    logic     queue_not_empty;
    logic     queue_pop;
    logic     queue_push;

    // A word is taken whenever the queue has a free slot.
    assign cmd_stall  = queue_full;
    assign queue_push = cmd_valid && !queue_full;

    hec_front #(
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_front (
        .req(cmd_word),
        .job(front_job)
    );

    hec_queue #(
        .DEPTH(HEC_QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (queue_push),
        .push_job (front_job),
        .full     (queue_full),
        .not_empty(queue_not_empty),
        .pop      (queue_pop),
        .head_job (head_job)
    );

    // The back end drains the queue as fast as the result port allows.
    hec_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(queue_not_empty),
        .job      (head_job),
        .job_pop  (queue_pop),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word (rsp_word)
    );

endmodule

>>> sv/hec_front.sv
// Front end: classifies a request word, sizes the code and masks unused bits.
`timescale 1ns / 1ps

module hec_front #(
    parameter int MAX_CODE_BITS = hec_pkg::HEC_MAX_CODE_BITS
) (
    input  hec_pkg::hec_req_t req,
    output hec_pkg::hec_job_t job
);
    import hec_pkg::*;

    logic [2:0]             enc_r;
    logic [6:0]             enc_len;
    logic                   enc_err;
    logic [HEC_COUNT_W-1:0] chk_len;
    logic [HEC_COUNT_W-1:0] keep_len;
    logic [HEC_WORD_W-1:0]  keep_mask;

    assign enc_r   = hec_parity_count(req.bit_count);
    assign enc_len = 7'(req.bit_count) + 7'(enc_r);
    assign enc_err = enc_len > 7'(MAX_CODE_BITS);

    // A check longer than the code limit is saturated to the limit.
    assign chk_len = (7'(req.bit_count) > 7'(MAX_CODE_BITS))
                   ? HEC_COUNT_W'(MAX_CODE_BITS) : req.bit_count;

    always_comb
    begin
        if (req.command == CMD_CHECK)
        begin
            keep_len = chk_len;
        end
        else if (enc_err)
        begin
            keep_len = '0;
        end
        else
        begin
            keep_len = req.bit_count;
        end
    end

    always_comb
    begin
        for (int i = 0; i < HEC_WORD_W; i++)
        begin
            keep_mask[HEC_COUNT_W'(i)] = 7'(i) < 7'(keep_len);
        end
    end

    always_comb
    begin
        job.is_check     = req.command == CMD_CHECK;
        job.length_error = (req.command == CMD_ENCODE) && enc_err;
        job.code_bits    = ((req.command == CMD_ENCODE) && !enc_err)
                         ? enc_len[HEC_COUNT_W-1:0] : '0;
        job.data         = req.word_bits & keep_mask;
    end

endmodule

>>> sv/hec_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module hec_queue #(
    parameter int DEPTH = hec_pkg::HEC_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hec_pkg::hec_job_t push_job,
    output logic              full,
    output logic              not_empty,
    input  logic              pop,
    output hec_pkg::hec_job_t head_job
);
    import hec_pkg::*;

    `include "hamming_encode_and_check_assert.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hec_job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `HEC_ASSERT_ALWAYS(a_count_bound, clk, !rst_n || count_reg <= CNT_W'(DEPTH))
    `HEC_ASSERT(a_pop_needs_entry, clk, rst_n, pop |-> count_reg != '0)
    `HEC_ASSERT(a_push_needs_room, clk, rst_n, (push && !pop) |-> !full)
    `HEC_ASSERT(a_ptr_gap, clk, rst_n,
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)

endmodule

>>> sv/hec_back.sv
// Back end: scatters data, builds parity or checks groups, holds the result word.
`timescale 1ns / 1ps

module hec_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  hec_pkg::hec_job_t job,
    output logic              job_pop,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output hec_pkg::hec_rsp_t rsp_word
);
    import hec_pkg::*;

    `include "hamming_encode_and_check_assert.svh"

    logic [HEC_WORD_W-1:0] scattered;
    logic [HEC_GROUPS-1:0] enc_par;
    logic [HEC_GROUPS-1:0] chk_par;
    logic [HEC_WORD_W-1:0] code;
    logic                  load;
    logic                  valid_reg;
    logic                  valid_next;
    hec_rsp_t              rsp_reg;
    hec_rsp_t              rsp_next;

    // Data bit d lands at the d-th code position that is not a power of two.
    always_comb
    begin
        scattered = '0;
        for (int d = 0; d < HEC_DATA_W; d++)
        begin
            scattered[hec_data_pos(d)] = job.data[HEC_COUNT_W'(d)];
        end
    end

    always_comb
    begin
        for (int g = 0; g < HEC_GROUPS; g++)
        begin
            enc_par[3'(g)] = ^(scattered & hec_group_mask(g));
            chk_par[3'(g)] = ^(job.data & hec_group_mask(g));
        end
    end

    always_comb
    begin
        code = scattered;
        for (int g = 0; g < HEC_GROUPS; g++)
        begin
            code[HEC_COUNT_W'((1 << g) - 1)] = enc_par[3'(g)];
        end
    end

    always_comb
    begin
        rsp_next = '0;
        if (job.is_check)
        begin
            rsp_next.parity_ok = ~|chk_par;
        end
        else if (job.length_error)
        begin
            rsp_next.length_error = 1'b1;
        end
        else
        begin
            rsp_next.code_word = code;
            rsp_next.code_bits = job.code_bits;
        end
    end

    assign load       = !valid_reg || !rsp_stall;
    assign job_pop    = job_valid && load;
    assign valid_next = load ? job_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_word  = rsp_reg;

    `HEC_ASSERT(a_err_no_code, clk, rst_n,
        (valid_reg && rsp_reg.length_error) |-> (rsp_reg.code_word == '0
            && rsp_reg.code_bits == '0 && !rsp_reg.parity_ok))
    `HEC_ASSERT(a_ok_only_check, clk, rst_n,
        (valid_reg && rsp_reg.parity_ok) |-> (rsp_reg.code_word == '0
            && rsp_reg.code_bits == '0))
    `HEC_ASSERT(a_code_in_length, clk, rst_n,
        (valid_reg && rsp_reg.code_bits == '0) |-> rsp_reg.code_word == '0)
    `HEC_ASSERT(a_pop_when_held, clk, rst_n,
        (valid_reg && rsp_stall) |-> !job_pop)

endmodule
